@@ rtl/cgpe_pkg.sv @@
package cgpe_pkg;

  localparam int GRID_ROWS      = 4;
  localparam int GENE_LIMIT     = 32;
  localparam int IN_TDATA_W     = 96;
  localparam int OUT_TDATA_W    = 8;
  localparam int SEL_W          = 6;

  localparam logic [7:0] BYTE_ONES   = 8'hFF;
  localparam logic [7:0] MASK_SHR1   = 8'h7F;
  localparam logic [7:0] MASK_SHR2   = 8'h3F;
  localparam logic [7:0] MASK_HI_NIB = 8'hF0;
  localparam logic [7:0] MASK_LO_NIB = 8'h0F;

  typedef enum logic [3:0] {
    FN_CONST   = 4'd0,
    FN_PASS    = 4'd1,
    FN_NOT     = 4'd2,
    FN_OR      = 4'd3,
    FN_NOTA_OR = 4'd4,
    FN_AND     = 4'd5,
    FN_NAND    = 4'd6,
    FN_XOR     = 4'd7,
    FN_SHR1    = 4'd8,
    FN_SHR2    = 4'd9,
    FN_SWAP    = 4'd10,
    FN_ADD     = 4'd11,
    FN_ADDSAT  = 4'd12,
    FN_AVG     = 4'd13,
    FN_MAX     = 4'd14,
    FN_MIN     = 4'd15
  } fn_t;

  typedef struct packed {
    logic             enabled;
    fn_t              func;
    logic [SEL_W-1:0] src_b;
    logic [SEL_W-1:0] src_a;
  } gene_t;

  typedef enum logic [2:0] {
    STEP_IDLE = 3'd0,
    STEP_GENE = 3'd1,
    STEP_OPND = 3'd2,
    STEP_EXEC = 3'd3,
    STEP_OSEL = 3'd4,
    STEP_DONE = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    JMP_SEQ,
    JMP_GO,
    JMP_LOOP,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic  gene_rd;
    logic  opnd_rd;
    logic  node_wr;
    logic  osel_rd;
    logic  res_ld;
    jmp_t  jmp;
    step_t target;
  } ucw_t;

  function automatic ucw_t ucode_rom(step_t step);
    ucw_t w;
    w = '{gene_rd: 1'b0, opnd_rd: 1'b0, node_wr: 1'b0, osel_rd: 1'b0, res_ld: 1'b0,
          jmp: JMP_GO, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.jmp    = JMP_WAIT_IN;
        w.target = STEP_GENE;
      end
      STEP_GENE: begin
        w.gene_rd = 1'b1;
        w.jmp     = JMP_SEQ;
      end
      STEP_OPND: begin
        w.opnd_rd = 1'b1;
        w.jmp     = JMP_SEQ;
      end
      STEP_EXEC: begin
        w.node_wr = 1'b1;
        w.jmp     = JMP_LOOP;
        w.target  = STEP_GENE;
      end
      STEP_OSEL: begin
        w.osel_rd = 1'b1;
        w.jmp     = JMP_SEQ;
      end
      STEP_DONE: begin
        w.res_ld = 1'b1;
        w.jmp    = JMP_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] prim_byte(logic [SEL_W-1:0] idx, logic [63:0] lo,
                                           logic [7:0] hi);
    logic [7:0] r;
    r = 8'd0;
    if (idx < SEL_W'(8)) begin
      r = lo[{idx[2:0], 3'b000} +: 8];
    end else if (idx == SEL_W'(8)) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

@@ rtl/cgp_grid_byte_evaluator.sv @@
// Byte-wide Cartesian genetic programming grid of four rows by GRID_COLUMNS columns with
// level-back one. An input transaction with tuser low loads one node gene; with tuser high it
// evaluates one window and produces one result transaction. An evaluation walks every node of
// the grid in turn through one function unit and one node-value memory, three microcode steps
// per node, and the block accepts no next input transaction until the window's result is
// loaded into the output register. Loads and configuration writes may arrive while an earlier
// result is still waiting on the output.
module cgp_grid_byte_evaluator
  import cgpe_pkg::*;
#(
  parameter int PRIMARY_INPUTS = 9,
  parameter int GRID_COLUMNS   = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // node_number[4:0], source_a[10:5], source_b[16:11], function_code[20:17],
  // node_enabled[21], window_low[85:22], window_high[93:86], zero fill above.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[0].
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // result_byte[7:0].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // source_fault[0].
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SEL_W-1:0]       cfg_data
);

  localparam int NODE_COUNT = GRID_ROWS * GRID_COLUMNS;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int NODE_SLOTS = 1 << NODE_W;
  localparam int GENE_DEPTH = (NODE_COUNT < GENE_LIMIT) ? NODE_COUNT : GENE_LIMIT;
  localparam int GENE_AW    = $clog2(GENE_DEPTH);
  localparam int GENE_SLOTS = 1 << GENE_AW;

  typedef struct packed {
    logic              prim;
    logic              bad;
    logic [7:0]        pbyte;
    logic [NODE_W-1:0] addr;
  } opnd_t;

  function automatic opnd_t decode_src(logic [SEL_W-1:0] s, logic [NODE_W-1:0] node,
                                       logic [63:0] lo, logic [7:0] hi);
    opnd_t      r;
    logic [8:0] m9;
    logic [8:0] col9;
    m9      = 9'(s) - 9'(PRIMARY_INPUTS);
    col9    = 9'(node >> 2);
    r.prim  = (int'(s) < PRIMARY_INPUTS);
    r.pbyte = prim_byte(s, lo, hi);
    r.addr  = m9[NODE_W-1:0];
    r.bad   = !r.prim && ((col9 == 9'd0) || ((m9 >> 2) != (col9 - 9'd1)));
    return r;
  endfunction

  step_t             step_r, step_nxt;
  ucw_t              ucw;
  logic [NODE_W-1:0] node_r;
  logic              fault_r;
  logic [SEL_W-1:0]  output_select_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_fault_r;

  logic [63:0]       win_lo_r;
  logic [7:0]        win_hi_r;

  gene_t             gene_mem [GENE_SLOTS];
  logic [GENE_SLOTS-1:0] gene_valid_r;
  gene_t             gene_q;
  logic              gene_live_r;

  logic [7:0]        nram [NODE_SLOTS];
  logic [7:0]        nram_a_q, nram_b_q;

  logic              op_en_r;
  fn_t               op_func_r;
  logic              opa_prim_r, opb_prim_r;
  logic [7:0]        opa_byte_r, opb_byte_r;
  logic              osel_prim_r, osel_node_r;

  logic              in_acc, eval_start, load_wr, node_last, out_free, res_take;
  logic              node_en;
  opnd_t             dec_a, dec_b;
  logic [8:0]        sel_m9;
  logic [NODE_W-1:0] rd_addr_a;
  logic [7:0]        alu_a, alu_b, alu_y, result_byte;
  gene_t             load_gene;

  assign ucw        = ucode_rom(step_r);
  assign in_tready  = (ucw.jmp == JMP_WAIT_IN);
  assign in_acc     = in_tvalid && in_tready;
  assign eval_start = in_acc && in_tuser;
  assign load_wr    = in_acc && !in_tuser && (int'(in_tdata[4:0]) < NODE_COUNT);
  assign node_last  = (node_r == NODE_W'(NODE_COUNT - 1));
  assign out_free   = !out_valid_r || out_tready;
  assign res_take   = ucw.res_ld && out_free;
  assign cfg_ready  = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_fault_r;

  assign load_gene.src_a   = in_tdata[10:5];
  assign load_gene.src_b   = in_tdata[16:11];
  assign load_gene.func    = fn_t'(in_tdata[20:17]);
  assign load_gene.enabled = in_tdata[21];

  always_comb begin
    unique case (ucw.jmp)
      JMP_SEQ:      step_nxt = step_t'(step_r + 3'd1);
      JMP_GO:       step_nxt = ucw.target;
      JMP_LOOP:     step_nxt = node_last ? step_t'(step_r + 3'd1) : ucw.target;
      JMP_WAIT_IN:  step_nxt = eval_start ? ucw.target : step_r;
      JMP_WAIT_OUT: step_nxt = out_free ? ucw.target : step_r;
      default:      step_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= STEP_IDLE;
      node_r          <= '0;
      fault_r         <= 1'b0;
      output_select_r <= SEL_W'(9);
      out_valid_r     <= 1'b0;
      gene_valid_r    <= '0;
    end else begin
      step_r <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        output_select_r <= cfg_data;
      end
      if (load_wr) begin
        gene_valid_r[in_tdata[GENE_AW-1:0]] <= 1'b1;
      end
      if (eval_start) begin
        node_r  <= '0;
        fault_r <= 1'b0;
      end else if (ucw.node_wr && !node_last) begin
        node_r <= node_r + NODE_W'(1);
      end
      if (ucw.opnd_rd && node_en && (dec_a.bad || dec_b.bad)) begin
        fault_r <= 1'b1;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      gene_mem[in_tdata[GENE_AW-1:0]] <= load_gene;
    end
    if (ucw.gene_rd) begin
      gene_q      <= gene_mem[node_r[GENE_AW-1:0]];
      gene_live_r <= (int'(node_r) < GENE_DEPTH) && gene_valid_r[node_r[GENE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (eval_start) begin
      win_lo_r <= in_tdata[85:22];
      win_hi_r <= in_tdata[93:86];
    end
  end

  assign node_en = gene_live_r && gene_q.enabled;
  assign dec_a   = decode_src(gene_q.src_a, node_r, win_lo_r, win_hi_r);
  assign dec_b   = decode_src(gene_q.src_b, node_r, win_lo_r, win_hi_r);
  assign sel_m9  = 9'(output_select_r) - 9'(PRIMARY_INPUTS);
  assign rd_addr_a = ucw.osel_rd ? sel_m9[NODE_W-1:0] : dec_a.addr;

  always_ff @(posedge clk) begin
    if (ucw.opnd_rd) begin
      op_en_r    <= node_en;
      op_func_r  <= gene_q.func;
      opa_prim_r <= dec_a.prim;
      opb_prim_r <= dec_b.prim;
      opa_byte_r <= dec_a.pbyte;
      opb_byte_r <= dec_b.pbyte;
    end
    if (ucw.osel_rd) begin
      osel_prim_r <= (int'(output_select_r) < PRIMARY_INPUTS);
      osel_node_r <= (int'(output_select_r) >= PRIMARY_INPUTS)
                     && (sel_m9 < 9'(NODE_COUNT));
      opa_byte_r  <= prim_byte(output_select_r, win_lo_r, win_hi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ucw.node_wr) begin
      nram[node_r] <= op_en_r ? alu_y : 8'd0;
    end
    if (ucw.opnd_rd || ucw.osel_rd) begin
      nram_a_q <= nram[rd_addr_a];
      nram_b_q <= nram[dec_b.addr];
    end
  end

  assign alu_a = opa_prim_r ? opa_byte_r : nram_a_q;
  assign alu_b = opb_prim_r ? opb_byte_r : nram_b_q;

  cgpe_alu u_alu (
    .func (op_func_r),
    .a    (alu_a),
    .b    (alu_b),
    .y    (alu_y)
  );

  always_comb begin
    priority if (fault_r) begin
      result_byte = 8'd0;
    end else if (osel_prim_r) begin
      result_byte = opa_byte_r;
    end else if (osel_node_r) begin
      result_byte = nram_a_q;
    end else begin
      result_byte = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_byte_r  <= result_byte;
      out_fault_r <= fault_r;
    end
  end

`ifndef SYNTHESIS
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == STEP_DONE))
    else $error("result raised outside the final step");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_byte_r == 8'd0))
    else $error("faulted result carries a non-zero byte");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(node_r) < NODE_COUNT)
    else $error("node counter beyond the grid");

  a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tuser))
    else $error("input stalled without an evaluate transaction");
`endif

endmodule

@@ rtl/cgpe_alu.sv @@
module cgpe_alu
  import cgpe_pkg::*;
(
  input  fn_t        func,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] y
);

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (func)
      FN_CONST:   y = BYTE_ONES;
      FN_PASS:    y = a;
      FN_NOT:     y = a ^ BYTE_ONES;
      FN_OR:      y = a | b;
      FN_NOTA_OR: y = (a ^ BYTE_ONES) | b;
      FN_AND:     y = a & b;
      FN_NAND:    y = (a & b) ^ BYTE_ONES;
      FN_XOR:     y = a ^ b;
      FN_SHR1:    y = (a >> 1) & MASK_SHR1;
      FN_SHR2:    y = (a >> 2) & MASK_SHR2;
      FN_SWAP:    y = ((a << 4) & MASK_HI_NIB) | (b & MASK_LO_NIB);
      FN_ADD:     y = sum[7:0];
      FN_ADDSAT:  y = sum[8] ? BYTE_ONES : sum[7:0];
      FN_AVG:     y = ((a >> 1) & MASK_SHR1) + ((b >> 1) & MASK_SHR1);
      FN_MAX:     y = (a > b) ? a : b;
      FN_MIN:     y = (a < b) ? a : b;
      default:    y = 8'd0;
    endcase
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import cgpe_pkg::*;

  localparam int PRIMARY       = 9;
  localparam int GRID_COLS     = 8;
  localparam int NODES         = GRID_ROWS * GRID_COLS;
  localparam int SETTLE_CYCLES = 3 * NODES + 3 + 20;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 710;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct {
    logic             action;
    logic [4:0]       node;
    logic [SEL_W-1:0] src_a;
    logic [SEL_W-1:0] src_b;
    fn_t              func;
    logic             en;
    logic [63:0]      win_lo;
    logic [7:0]       win_hi;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       fault;
  } window_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SEL_W-1:0]       cfg_data = '0;

  gene_t            gene_mem [NODES];
  logic [SEL_W-1:0] output_select;
  window_result_t   pending_results [$];
  int               failures = 0;
  int               cycle_count = 0;
  int               in_gap_pct = 30;
  int               out_stall_pct = 30;

  cgp_grid_byte_evaluator #(
    .PRIMARY_INPUTS(PRIMARY),
    .GRID_COLUMNS  (GRID_COLS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] window_byte(logic [SEL_W-1:0] idx, logic [63:0] lo,
                                             logic [7:0] hi);
    if (idx < 8) return lo[idx * 8 +: 8];
    if (idx == 8) return hi;
    return 8'd0;
  endfunction

  function automatic logic [7:0] node_op(fn_t f, logic [7:0] a, logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    case (f)
      FN_CONST:   return 8'hFF;
      FN_PASS:    return a;
      FN_NOT:     return ~a;
      FN_OR:      return a | b;
      FN_NOTA_OR: return ~a | b;
      FN_AND:     return a & b;
      FN_NAND:    return ~(a & b);
      FN_XOR:     return a ^ b;
      FN_SHR1:    return {1'b0, a[7:1]};
      FN_SHR2:    return {2'b00, a[7:2]};
      FN_SWAP:    return {a[3:0], b[3:0]};
      FN_ADD:     return sum[7:0];
      FN_ADDSAT:  return sum[8] ? 8'hFF : sum[7:0];
      FN_AVG:     return {1'b0, a[7:1]} + {1'b0, b[7:1]};
      FN_MAX:     return (a > b) ? a : b;
      default:    return (a < b) ? a : b;
    endcase
  endfunction

  // Walks the grid in node order, so every operand from the previous column is ready.
  function automatic window_result_t predict_window(logic [63:0] lo, logic [7:0] hi);
    logic [7:0]       val [NODES];
    logic [7:0]       opnd [2];
    logic [SEL_W-1:0] src;
    logic             bad;
    int               col;
    int               first;
    window_result_t   r;
    bad = 1'b0;
    for (int n = 0; n < NODES; n++) begin
      col = n / GRID_ROWS;
      if (!gene_mem[n].enabled) begin
        val[n] = 8'd0;
      end else begin
        for (int k = 0; k < 2; k++) begin
          src = k ? gene_mem[n].src_b : gene_mem[n].src_a;
          first = PRIMARY + (col - 1) * GRID_ROWS;
          if (src < PRIMARY) begin
            opnd[k] = window_byte(src, lo, hi);
          end else if (col == 0 || src < first || src >= first + GRID_ROWS) begin
            bad = 1'b1;
            opnd[k] = 8'd0;
          end else begin
            opnd[k] = val[src - PRIMARY];
          end
        end
        val[n] = node_op(gene_mem[n].func, opnd[0], opnd[1]);
      end
    end
    r.fault = bad;
    r.byte_val = 8'd0;
    if (!bad) begin
      if (output_select < PRIMARY) r.byte_val = window_byte(output_select, lo, hi);
      else if (output_select - PRIMARY < NODES) r.byte_val = val[output_select - PRIMARY];
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_item(stream_item_t it);
    return {2'b00, it.win_hi, it.win_lo, it.en, it.func, it.src_b, it.src_a, it.node};
  endfunction

  function automatic stream_item_t random_item(logic act);
    stream_item_t it;
    it.action = act;
    it.node   = 5'($urandom);
    it.src_a  = SEL_W'($urandom);
    it.src_b  = SEL_W'($urandom);
    it.func   = fn_t'($urandom_range(15));
    it.en     = 1'($urandom);
    it.win_lo = {$urandom, $urandom};
    it.win_hi = 8'($urandom);
    return it;
  endfunction

  function automatic stream_item_t make_load(int node, int a, int b, fn_t f, logic en);
    stream_item_t it;
    it = random_item(ACT_LOAD);
    it.node  = 5'(node);
    it.src_a = SEL_W'(a);
    it.src_b = SEL_W'(b);
    it.func  = f;
    it.en    = en;
    return it;
  endfunction

  function automatic stream_item_t make_eval(logic [63:0] lo, logic [7:0] hi);
    stream_item_t it;
    it = random_item(ACT_EVAL);
    it.win_lo = lo;
    it.win_hi = hi;
    return it;
  endfunction

  function automatic logic [SEL_W-1:0] legal_source(int col);
    if (col == 0 || $urandom_range(3) == 0) return SEL_W'($urandom_range(PRIMARY - 1));
    return SEL_W'(PRIMARY + (col - 1) * GRID_ROWS + $urandom_range(GRID_ROWS - 1));
  endfunction

  function automatic stream_item_t legal_load(int node);
    stream_item_t it;
    it = random_item(ACT_LOAD);
    it.node  = 5'(node);
    it.src_a = legal_source(node / GRID_ROWS);
    it.src_b = legal_source(node / GRID_ROWS);
    it.en    = ($urandom_range(9) != 0);
    return it;
  endfunction

  // The valid is only lowered for a gap, so back-to-back transactions keep it high.
  task automatic send_item(input stream_item_t it);
    if ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_item(it);
    in_tuser  <= it.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.action == ACT_EVAL) begin
      pending_results.push_back(predict_window(it.win_lo, it.win_hi));
    end else begin
      gene_mem[it.node] = '{enabled: it.en, func: it.func, src_b: it.src_b, src_a: it.src_a};
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_output_select(input logic [SEL_W-1:0] sel);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= sel;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    output_select = sel;
  endtask

  task automatic test_after_reset();
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
  endtask

  // Sixteen nodes, one per function, chained over four columns and folded by XOR nodes
  // into a single output, so that one window exercises the whole function set.
  task automatic test_function_set();
    int col;
    int row;
    int prev;
    set_output_select(SEL_W'(PRIMARY + 20));
    for (int n = 0; n < 16; n++) begin
      col = n / GRID_ROWS;
      row = n % GRID_ROWS;
      prev = PRIMARY + (col - 1) * GRID_ROWS;
      if (col == 0) send_item(make_load(n, row, PRIMARY - 1 - row, fn_t'(n), 1'b1));
      else send_item(make_load(n, prev + row, prev + (row + 1) % GRID_ROWS, fn_t'(n), 1'b1));
    end
    send_item(make_load(16, PRIMARY + 12, PRIMARY + 13, FN_XOR, 1'b1));
    send_item(make_load(17, PRIMARY + 14, PRIMARY + 15, FN_XOR, 1'b1));
    send_item(make_load(20, PRIMARY + 16, PRIMARY + 17, FN_XOR, 1'b1));
    send_item(make_eval('1, 8'hFF));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
  endtask

  task automatic test_output_routing();
    set_output_select(SEL_W'(0));
    send_item(make_eval('0, 8'h00));
    set_output_select(SEL_W'(PRIMARY - 1));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
    set_output_select(SEL_W'(PRIMARY + NODES - 1));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
    set_output_select('1);
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
    // A disabled node feeding the output tree must read as zero.
    set_output_select(SEL_W'(PRIMARY + 20));
    send_item(make_load(12, PRIMARY + 8, PRIMARY + 9, FN_MAX, 1'b0));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
  endtask

  task automatic test_source_faults();
    // A constant node still checks both operands.
    send_item(make_load(31, 0, 63, FN_CONST, 1'b1));
    send_item(make_eval('1, 8'hFF));
    // An operand two columns back is outside the level-back window.
    send_item(make_load(31, PRIMARY + 20, PRIMARY + 24, FN_PASS, 1'b1));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
    // Disabled nodes are not checked, but a node in the first column may not read a node.
    send_item(make_load(31, PRIMARY + 20, 63, FN_PASS, 1'b0));
    send_item(make_load(0, PRIMARY, 0, FN_OR, 1'b1));
    send_item(make_eval({$urandom, $urandom}, 8'($urandom)));
  endtask

  task automatic test_random_programs();
    int               sent;
    int               prog;
    int               loads;
    int               pick;
    bit               dirty;
    logic [SEL_W-1:0] sel;
    stream_item_t     it;
    sent = 0;
    prog = 0;
    dirty = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(19);
      if (pick < 3) sel = SEL_W'($urandom_range(PRIMARY - 1));
      else if (pick == 3) sel = SEL_W'($urandom_range(PRIMARY + NODES, 63));
      else if (pick < 10) sel = SEL_W'($urandom_range(PRIMARY + NODES - 8, PRIMARY + NODES - 1));
      else sel = SEL_W'($urandom_range(PRIMARY, PRIMARY + NODES - 1));
      set_output_select(sel);
      in_gap_pct    = (prog >= 8 && prog < 12) ? 0 : 30;
      out_stall_pct = in_gap_pct;
      loads = dirty ? NODES : $urandom_range(4, 12);
      for (int k = 0; k < loads; k++) begin
        send_item(legal_load(dirty ? k : $urandom_range(NODES - 1)));
        sent++;
      end
      dirty = ($urandom_range(3) == 0);
      if (dirty) begin
        repeat ($urandom_range(1, 2)) begin
          send_item(random_item(ACT_LOAD));
          sent++;
        end
      end
      repeat ($urandom_range(6, 14)) begin
        if ($urandom_range(7) == 0) begin
          send_item(legal_load($urandom_range(NODES - 1)));
          sent++;
        end
        it = random_item(ACT_EVAL);
        pick = $urandom_range(9);
        if (pick == 0) begin
          it.win_lo = '0;
          it.win_hi = 8'h00;
        end else if (pick == 1) begin
          it.win_lo = '1;
          it.win_hi = 8'hFF;
        end
        send_item(it);
        sent++;
      end
      prog++;
    end
    in_gap_pct = 30;
    out_stall_pct = 30;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    window_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: result_byte %0h, source_fault %0b",
               out_tdata, out_tuser);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata !== exp_res.byte_val) begin
          $error("result_byte: expected %0h, actual %0h", exp_res.byte_val, out_tdata);
          failures++;
        end
        if (out_tuser !== exp_res.fault) begin
          $error("source_fault: expected %0b, actual %0b", exp_res.fault, out_tuser);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int n = 0; n < NODES; n++) gene_mem[n] = '0;
    output_select = 6'd9;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_function_set();
    test_output_routing();
    test_source_faults();
    test_random_programs();
    wait_idle();
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
